// ===== rtl/core/cvl_pkg.sv =====
`default_nettype none

package cvl_pkg;

    // Default list depth
    localparam int CAPACITY_DEF = 32;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;
    localparam int SCOUNT_W = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ENTRY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // What every cell of the chain does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_COMPACT,
        CELL_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/cvl_cell.sv =====
`default_nettype none

module cvl_cell #(
    parameter int CAPACITY = cvl_pkg::CAPACITY_DEF,
    parameter int IDX      = 0,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int IDX_W   = $clog2(CAPACITY)
) (
    input  wire                                  clk,
    input  wire  cvl_pkg::cell_cmd_t             cmd,
    input  wire  [CNT_W-1:0]                     count,
    input  wire  [IDX_W-1:0]                     del_pos,
    input  wire  signed [cvl_pkg::DATA_W-1:0]    next_value,
    input  wire  signed [cvl_pkg::DATA_W-1:0]    head_value,
    output logic signed [cvl_pkg::DATA_W-1:0]    value_out
);

    logic signed [cvl_pkg::DATA_W-1:0] value_reg;
    logic signed [cvl_pkg::DATA_W-1:0] value_next;
    logic                              is_tail;
    logic                              in_ring;
    logic                              at_or_after;
    logic                              is_free;

    // Locate this cell relative to the stored entries
    assign is_tail     = (count == CNT_W'(IDX + 1));
    assign in_ring     = (CNT_W'(IDX + 1) < count);
    assign at_or_after = (IDX_W'(IDX) >= del_pos);
    assign is_free     = (count == CNT_W'(IDX));

    // Pick the next value: rotate the ring, close a gap, or take a new item
    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            cvl_pkg::CELL_ROTATE:
            begin
                if (is_tail)
                    value_next = head_value;
                else if (in_ring)
                    value_next = next_value;
            end
            cvl_pkg::CELL_COMPACT:
            begin
                if (at_or_after)
                    value_next = next_value;
            end
            cvl_pkg::CELL_WRITE:
            begin
                if (is_free)
                    value_next = cmd.data;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_out = value_reg;

endmodule

`default_nettype wire

// ===== rtl/core/compacting_value_list.sv =====
`default_nettype none

// Compacting value list: a packed list of up to CAPACITY signed 32-bit values
// held in a ring of cells. Insert appends once the output register is free
// (or reports full). Delete, search and list walk the ring: every cycle the
// cells rotate one place toward cell 0 and the head cell is examined, and a
// walk leaves the order as it was. Delete closes the gap as it puts out its
// result. One item is worked on at a time: in_stall is high from the cycle
// after an item is taken until its last result is in the output register, and
// a stalled output holds the walk. Each result comes out with last set on the
// final one of its item.
module compacting_value_list #(
    parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire  [cvl_pkg::OP_W-1:0]              operation,
    input  wire  signed [cvl_pkg::DATA_W-1:0]     value,
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic [cvl_pkg::STATUS_W-1:0]          status,
    output logic [cvl_pkg::POS_W-1:0]             position,
    output logic signed [cvl_pkg::DATA_W-1:0]     entry_value,
    output logic [cvl_pkg::SCOUNT_W-1:0]          stored_count,
    output logic                                  last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // Sequencer and item registers
    cvl_pkg::state_t                   state_reg, state_next;
    logic [cvl_pkg::OP_W-1:0]          op_reg, op_next;
    logic signed [cvl_pkg::DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [CNT_W-1:0]                  idx_reg, idx_next;
    logic                              found_reg, found_next;
    logic [IDX_W-1:0]                  del_pos_reg, del_pos_next;
    logic [IDX_W-1:0]                  pend_pos_reg, pend_pos_next;
    logic signed [cvl_pkg::DATA_W-1:0] pend_val_reg, pend_val_next;

    // Output register
    logic                              out_valid_reg, out_valid_next;
    logic [cvl_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [cvl_pkg::POS_W-1:0]         position_reg, position_next;
    logic signed [cvl_pkg::DATA_W-1:0] entry_value_reg, entry_value_next;
    logic [cvl_pkg::SCOUNT_W-1:0]      stored_count_reg, stored_count_next;
    logic                              last_reg, last_next;

    // Chain wiring
    cvl_pkg::cell_cmd_t                cmd;
    logic signed [cvl_pkg::DATA_W-1:0] cell_val [CAPACITY];
    logic signed [cvl_pkg::DATA_W-1:0] head_val;

    logic load;
    logic accept;
    logic scan_done;
    logic head_match;
    logic list_last;
    logic is_full;

    assign load       = !out_valid_reg || !out_stall;
    assign accept     = in_valid && !in_stall;
    assign head_val   = cell_val[0];
    assign scan_done  = (idx_reg == count_reg);
    assign head_match = (head_val == val_reg);
    assign list_last  = ((idx_reg + CNT_W'(1)) == count_reg);
    assign is_full    = (count_reg == CNT_W'(CAPACITY));

    // Build the ring of cells; the last cell sees itself as its neighbor
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [cvl_pkg::DATA_W-1:0] nbr;
        if (g == CAPACITY - 1)
        begin : g_end
            assign nbr = cell_val[g];
        end
        else
        begin : g_mid
            assign nbr = cell_val[g + 1];
        end

        cvl_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .del_pos    (del_pos_reg),
            .next_value (nbr),
            .head_value (head_val),
            .value_out  (cell_val[g])
        );
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvl_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = (operation == cvl_pkg::OP_INSERT) ?
                                 cvl_pkg::ST_INSERT : cvl_pkg::ST_SCAN;
            end
            cvl_pkg::ST_INSERT:
            begin
                if (load)
                    state_next = cvl_pkg::ST_IDLE;
            end
            cvl_pkg::ST_SCAN:
            begin
                if (scan_done)
                    state_next = cvl_pkg::ST_FINISH;
                else if (load && op_reg == cvl_pkg::OP_LIST && list_last)
                    state_next = cvl_pkg::ST_IDLE;
            end
            cvl_pkg::ST_FINISH:
            begin
                if (load)
                    state_next = cvl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cvl_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive the chain, the item registers and the output register
    always_comb
    begin
        op_next           = op_reg;
        val_next          = val_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        found_next        = found_reg;
        del_pos_next      = del_pos_reg;
        pend_pos_next     = pend_pos_reg;
        pend_val_next     = pend_val_reg;
        cmd.op            = cvl_pkg::CELL_HOLD;
        cmd.data          = val_reg;
        out_valid_next    = out_valid_reg && out_stall;
        status_next       = status_reg;
        position_next     = position_reg;
        entry_value_next  = entry_value_reg;
        stored_count_next = stored_count_reg;
        last_next         = last_reg;

        case (state_reg)
            cvl_pkg::ST_IDLE:
            begin
                // Take the item and start a fresh walk
                if (accept)
                begin
                    op_next    = operation;
                    val_next   = value;
                    idx_next   = '0;
                    found_next = 1'b0;
                end
            end
            cvl_pkg::ST_INSERT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (is_full)
                    begin
                        status_next       = cvl_pkg::STAT_FULL;
                        position_next     = '0;
                        entry_value_next  = '0;
                        stored_count_next = cvl_pkg::SCOUNT_W'(count_reg);
                    end
                    else
                    begin
                        cmd.op            = cvl_pkg::CELL_WRITE;
                        count_next        = count_reg + CNT_W'(1);
                        status_next       = cvl_pkg::STAT_DONE;
                        position_next     = cvl_pkg::POS_W'(count_reg);
                        entry_value_next  = val_reg;
                        stored_count_next = cvl_pkg::SCOUNT_W'(count_reg + CNT_W'(1));
                    end
                end
            end
            cvl_pkg::ST_SCAN:
            begin
                // Examine the head cell and rotate the ring one place
                if (load && !scan_done)
                begin
                    cmd.op   = cvl_pkg::CELL_ROTATE;
                    idx_next = idx_reg + CNT_W'(1);
                    case (op_reg)
                        cvl_pkg::OP_LIST:
                        begin
                            out_valid_next    = 1'b1;
                            status_next       = cvl_pkg::STAT_ENTRY;
                            position_next     = cvl_pkg::POS_W'(idx_reg[IDX_W-1:0]);
                            entry_value_next  = head_val;
                            stored_count_next = cvl_pkg::SCOUNT_W'(count_reg);
                            last_next         = list_last;
                        end
                        cvl_pkg::OP_SEARCH:
                        begin
                            // Hold one match back so the final one can carry last
                            if (head_match)
                            begin
                                if (found_reg)
                                begin
                                    out_valid_next    = 1'b1;
                                    status_next       = cvl_pkg::STAT_ENTRY;
                                    position_next     = cvl_pkg::POS_W'(pend_pos_reg);
                                    entry_value_next  = pend_val_reg;
                                    stored_count_next = cvl_pkg::SCOUNT_W'(count_reg);
                                    last_next         = 1'b0;
                                end
                                found_next    = 1'b1;
                                pend_pos_next = idx_reg[IDX_W-1:0];
                                pend_val_next = head_val;
                            end
                        end
                        cvl_pkg::OP_DELETE:
                        begin
                            if (head_match && !found_reg)
                            begin
                                found_next   = 1'b1;
                                del_pos_next = idx_reg[IDX_W-1:0];
                            end
                        end
                        default:
                        begin
                            found_next = found_reg;
                        end
                    endcase
                end
            end
            cvl_pkg::ST_FINISH:
            begin
                if (load)
                begin
                    out_valid_next    = 1'b1;
                    last_next         = 1'b1;
                    position_next     = '0;
                    entry_value_next  = '0;
                    stored_count_next = cvl_pkg::SCOUNT_W'(count_reg);
                    if (op_reg == cvl_pkg::OP_LIST)
                    begin
                        status_next = cvl_pkg::STAT_EMPTY;
                    end
                    else if (!found_reg)
                    begin
                        status_next = cvl_pkg::STAT_NOTFOUND;
                    end
                    else if (op_reg == cvl_pkg::OP_SEARCH)
                    begin
                        status_next      = cvl_pkg::STAT_ENTRY;
                        position_next    = cvl_pkg::POS_W'(pend_pos_reg);
                        entry_value_next = pend_val_reg;
                    end
                    else
                    begin
                        // Drop the matched entry and close the gap
                        cmd.op            = cvl_pkg::CELL_COMPACT;
                        count_next        = count_reg - CNT_W'(1);
                        status_next       = cvl_pkg::STAT_DONE;
                        position_next     = cvl_pkg::POS_W'(del_pos_reg);
                        entry_value_next  = val_reg;
                        stored_count_next = cvl_pkg::SCOUNT_W'(count_reg - CNT_W'(1));
                    end
                end
            end
            default:
            begin
                cmd.op = cvl_pkg::CELL_HOLD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cvl_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        val_reg          <= val_next;
        del_pos_reg      <= del_pos_next;
        pend_pos_reg     <= pend_pos_next;
        pend_val_reg     <= pend_val_next;
        status_reg       <= status_next;
        position_reg     <= position_next;
        entry_value_reg  <= entry_value_next;
        stored_count_reg <= stored_count_next;
        last_reg         <= last_next;
    end

    assign in_stall     = (state_reg != cvl_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign position     = position_reg;
    assign entry_value  = entry_value_reg;
    assign stored_count = stored_count_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cvl_checker.sv =====
`default_nettype none

module cvl_checker #(
    parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                in_valid,
    input wire                                in_stall,
    input wire                                out_valid,
    input wire                                out_stall,
    input wire [cvl_pkg::STATUS_W-1:0]        status,
    input wire [cvl_pkg::POS_W-1:0]           position,
    input wire signed [cvl_pkg::DATA_W-1:0]   entry_value,
    input wire [cvl_pkg::SCOUNT_W-1:0]        stored_count,
    input wire                                last
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(position)
            && $stable(entry_value) && $stable(stored_count) && $stable(last))
    else $error("stalled result changed");

    // One item at a time: stall right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is at work");

    // Single-result statuses always close the item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cvl_pkg::STAT_DONE || status == cvl_pkg::STAT_FULL
            || status == cvl_pkg::STAT_NOTFOUND || status == cvl_pkg::STAT_EMPTY)
        |-> last)
    else $error("single result without last");

    // Full report only when the list holds CAPACITY entries
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cvl_pkg::STAT_FULL
        |-> stored_count == cvl_pkg::SCOUNT_W'(CAPACITY))
    else $error("full reported below capacity");

    // Empty report carries a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cvl_pkg::STAT_EMPTY |-> stored_count == '0)
    else $error("empty reported with entries stored");

endmodule

bind compacting_value_list cvl_checker #(.CAPACITY(CAPACITY)) u_cvl_checker (.*);

`default_nettype wire

// ===== bench/compacting_value_list_tb.sv =====
`timescale 1ns / 100ps

module compacting_value_list_tb;
    import cvl_pkg::*;

    localparam int LIST_DEPTH  = CAPACITY_DEF;
    localparam int MAX_REPORTS = 10;
    localparam int IDLE_PCT    = 13;
    localparam int POOL_SIZE   = 8;

    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] entry_value;
        logic [SCOUNT_W-1:0]      stored_count;
        logic                     last;
    } list_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          operation = OP_INSERT;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] entry_value;
    logic [SCOUNT_W-1:0]      stored_count;
    logic                     last;

    // Expected results in order, and the list contents as the block should hold them
    list_result_t             pending_results[$];
    logic signed [DATA_W-1:0] shadow_list[$];
    logic signed [DATA_W-1:0] value_pool[POOL_SIZE];

    int err_count    = 0;
    bit jitter_on    = 1'b1;
    bit hold_request = 1'b0;

    compacting_value_list #(
        .CAPACITY(LIST_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .position(position),
        .entry_value(entry_value),
        .stored_count(stored_count),
        .last(last)
    );

    always #4 clk = ~clk;

    initial
    begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic void push_result(logic [STATUS_W-1:0] code, int idx,
                                        logic signed [DATA_W-1:0] val, bit fin);
        list_result_t r;
        r.status       = code;
        r.position     = idx[POS_W-1:0];
        r.entry_value  = val;
        r.stored_count = SCOUNT_W'(shadow_list.size());
        r.last         = fin;
        pending_results.push_back(r);
    endfunction

    // Apply one item to the shadow list and queue the results it causes
    function automatic void predict_list_op(logic [OP_W-1:0] op,
                                            logic signed [DATA_W-1:0] val);
        int found;
        int hit_idx[$];
        found = -1;
        case (op)
            OP_INSERT:
            begin
                if (shadow_list.size() >= LIST_DEPTH)
                    push_result(STAT_FULL, 0, '0, 1'b1);
                else
                begin
                    shadow_list.push_back(val);
                    push_result(STAT_DONE, shadow_list.size() - 1, val, 1'b1);
                end
            end
            OP_DELETE:
            begin
                for (int i = 0; i < shadow_list.size(); i++)
                begin
                    if (found < 0 && shadow_list[i] == val)
                        found = i;
                end
                if (found < 0)
                    push_result(STAT_NOTFOUND, 0, '0, 1'b1);
                else
                begin
                    shadow_list.delete(found);
                    push_result(STAT_DONE, found, val, 1'b1);
                end
            end
            OP_SEARCH:
            begin
                for (int i = 0; i < shadow_list.size(); i++)
                begin
                    if (shadow_list[i] == val)
                        hit_idx.push_back(i);
                end
                if (hit_idx.size() == 0)
                    push_result(STAT_NOTFOUND, 0, '0, 1'b1);
                foreach (hit_idx[k])
                    push_result(STAT_ENTRY, hit_idx[k], shadow_list[hit_idx[k]],
                                k == hit_idx.size() - 1);
            end
            default:
            begin
                if (shadow_list.size() == 0)
                    push_result(STAT_EMPTY, 0, '0, 1'b1);
                foreach (shadow_list[i])
                    push_result(STAT_ENTRY, i, shadow_list[i], i == shadow_list.size() - 1);
            end
        endcase
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
        bit taken;
        while (jitter_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= val;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        predict_list_op(op, val);
    endtask

    // Pause the input until every expected result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Drive the output stall: a long hold-off on request, else random stalls
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= jitter_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Compare each result taken at the coming edge with the oldest expectation
    always @(negedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, position, entry_value, stored_count, last};
            if (pending_results.size() == 0)
                note_error($sformatf("unexpected result: status %0d pos %0d value %0d",
                                     got.status, got.position, got.entry_value));
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    note_error($sformatf({"result mismatch: expected status %0d pos %0d ",
                        "value %0d count %0d last %0d, got status %0d pos %0d value %0d ",
                        "count %0d last %0d"},
                        want.status, want.position, want.entry_value, want.stored_count,
                        want.last, got.status, got.position, got.entry_value,
                        got.stored_count, got.last));
            end
        end
    end

    function automatic void refresh_pool();
        value_pool[0] = MOST_NEGATIVE;
        value_pool[1] = MOST_POSITIVE;
        value_pool[2] = $urandom_range(3);
        for (int i = 3; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
    endfunction

    // Mostly values that can match, sometimes fully random ones
    function automatic logic signed [DATA_W-1:0] pick_value(int list_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < list_pct && shadow_list.size() != 0)
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        if (roll < 85)
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int ins_pct, int del_pct, int srch_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < ins_pct)
            return OP_INSERT;
        if (roll < ins_pct + del_pct)
            return OP_DELETE;
        if (roll < ins_pct + del_pct + srch_pct)
            return OP_SEARCH;
        return OP_LIST;
    endfunction

    task automatic test_empty_list();
        send_item(OP_LIST, $urandom);
        send_item(OP_DELETE, '0);
        send_item(OP_SEARCH, MOST_NEGATIVE);
    endtask

    task automatic test_extremes();
        send_item(OP_INSERT, MOST_NEGATIVE);
        send_item(OP_INSERT, MOST_POSITIVE);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, -1);
        send_item(OP_INSERT, MOST_POSITIVE);
        // two matches, then none
        send_item(OP_SEARCH, MOST_POSITIVE);
        send_item(OP_SEARCH, 1);
        send_item(OP_LIST, '1);
        // remove first of duplicates, a middle entry, and a missing value
        send_item(OP_DELETE, MOST_POSITIVE);
        send_item(OP_DELETE, -1);
        send_item(OP_DELETE, 7);
        send_item(OP_LIST, '0);
        // empty it again
        send_item(OP_DELETE, MOST_NEGATIVE);
        send_item(OP_DELETE, '0);
        send_item(OP_DELETE, MOST_POSITIVE);
        send_item(OP_LIST, '0);
        send_item(OP_SEARCH, '0);
    endtask

    task automatic test_full_list();
        refresh_pool();
        while (shadow_list.size() < LIST_DEPTH)
            send_item(OP_INSERT, pick_value(0));
        // overflow, then look at a full list
        send_item(OP_INSERT, $urandom);
        send_item(OP_INSERT, MOST_NEGATIVE);
        send_item(OP_LIST, $urandom);
        send_item(OP_SEARCH, value_pool[$urandom_range(POOL_SIZE - 1)]);
        send_item(OP_DELETE, shadow_list[LIST_DEPTH / 2]);
        send_item(OP_INSERT, $urandom);
        send_item(OP_INSERT, $urandom);
        wait_drained();
        // take everything out from random positions
        while (shadow_list.size() != 0)
            send_item(OP_DELETE, pick_value(100));
        send_item(OP_LIST, $urandom);
    endtask

    task automatic test_backpressure();
        refresh_pool();
        hold_request = 1'b1;
        repeat (24)
            send_item(pick_op(45, 20, 20), pick_value(50));
        wait_drained();
    endtask

    task automatic test_random_mix(int n_items, int ins_pct, int del_pct);
        refresh_pool();
        repeat (n_items)
        begin
            send_item(pick_op(ins_pct, del_pct, (100 - ins_pct - del_pct) / 2),
                      pick_value(60));
            if ($urandom_range(99) < 3)
                wait_drained();
        end
    endtask

    initial
    begin
        int wait_left;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_extremes();
        test_full_list();
        test_backpressure();
        test_random_mix(100, 55, 15);
        test_random_mix(90, 20, 50);
        // a stretch with no idling on either side
        jitter_on = 1'b0;
        test_random_mix(80, 55, 15);
        jitter_on = 1'b1;
        test_random_mix(80, 25, 45);

        // let the last results drain, with a limit
        in_valid <= 1'b0;
        wait_left = 200000;
        while (pending_results.size() != 0 && wait_left > 0)
        begin
            @(posedge clk);
            wait_left--;
        end
        repeat (LIST_DEPTH + 8) @(posedge clk);
        if (pending_results.size() != 0)
            note_error($sformatf("%0d expected results never arrived",
                                 pending_results.size()));

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== compacting_value_list.f =====
rtl/core/cvl_pkg.sv
rtl/core/cvl_cell.sv
rtl/core/compacting_value_list.sv
rtl/core/cvl_checker.sv
bench/compacting_value_list_tb.sv
